// File: sv/dtwq_pkg.sv
// ----------------------------------------------------------------------------
// dtwq_pkg: shared types and constants of the two-tier work queue
// Kind codes, payload structs and default depths.
// ----------------------------------------------------------------------------
package dtwq_pkg;

  localparam int unsigned MainDepthDef = 32;
  localparam int unsigned IdleDepthDef = 32;
  localparam int unsigned MaxResults   = 32;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned KeyW         = 3 * CoordW;
  localparam int unsigned LimitW       = 6;

  typedef enum logic [2:0] {
    KIND_DIRTY  = 3'd0,
    KIND_REMESH = 3'd1,
    KIND_IDLE   = 3'd2,
    KIND_FRAME  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                     emit;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     promoted;
    logic                     added;
    logic                     overflow;
    logic                     last;
  } out_item_t;

  // Control handed to every cell of a queue chain at once.
  typedef struct packed {
    logic push;   // write key into the cell at the tail
    logic shift;  // move each entry one place towards the head
    logic clear;  // drop every entry
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MARK  = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

endpackage

// File: sv/dtwq_cell.sv
// ----------------------------------------------------------------------------
// dtwq_cell: one entry of a queue chain
// Holds a key and a valid flag, compares against the search key and takes
// the neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module dtwq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dtwq_pkg::chain_ctl_t     ctl_i,
  input  logic                     is_tail_i,
  input  logic [dtwq_pkg::KeyW-1:0] key_i,
  input  logic                     nb_valid_i,
  input  logic [dtwq_pkg::KeyW-1:0] nb_key_i,
  output logic                     valid_o,
  output logic [dtwq_pkg::KeyW-1:0] key_o,
  output logic                     hit_o
);

  logic                      valid_q, valid_d;
  logic [dtwq_pkg::KeyW-1:0] key_q, key_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      valid_d = nb_valid_i;
      key_d   = nb_key_i;
    end else if (ctl_i.push && is_tail_i) begin
      valid_d = 1'b1;
      key_d   = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign hit_o   = valid_q && (key_q == key_i);

endmodule

// File: sv/dtwq_chain.sv
// ----------------------------------------------------------------------------
// dtwq_chain: row of cells forming one deduplicating FIFO
// Head at cell 0; shift moves entries towards the head.
// ----------------------------------------------------------------------------
module dtwq_chain #(
  parameter int unsigned Depth = dtwq_pkg::MainDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtwq_pkg::chain_ctl_t      ctl_i,
  input  logic [dtwq_pkg::KeyW-1:0] key_i,
  output logic                      hit_o,
  output logic                      full_o,
  output logic                      empty_o,
  output logic                      more_o,
  output logic [dtwq_pkg::KeyW-1:0] head_o
);

  logic [Depth-1:0]                 valid;
  logic [Depth-1:0]                 hit;
  logic [Depth-1:0]                 tail;
  logic [Depth:0]                   nb_valid;
  logic [dtwq_pkg::KeyW-1:0]        keys [Depth+1];

  assign nb_valid[Depth] = 1'b0;
  assign keys[Depth]     = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // Tail is the first empty cell; entries are always packed at the head.
    if (i == 0) begin : g_head
      assign tail[i] = !valid[i];
    end else begin : g_body
      assign tail[i] = !valid[i] && valid[i-1];
    end
    dtwq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .is_tail_i  (tail[i]),
      .key_i      (key_i),
      .nb_valid_i (nb_valid[i+1]),
      .nb_key_i   (keys[i+1]),
      .valid_o    (valid[i]),
      .key_o      (keys[i]),
      .hit_o      (hit[i])
    );
    assign nb_valid[i] = valid[i];
  end

  assign hit_o   = |hit;
  assign full_o  = valid[Depth-1];
  assign empty_o = !valid[0];
  // An entry waits behind the head.
  assign more_o  = valid[1];
  assign head_o  = keys[0];

endmodule

// File: sv/dtwq_ctrl.sv
// ----------------------------------------------------------------------------
// dtwq_ctrl: sequencer of the work queue
// Decodes an item, drives both chains and forms the result items.
// ----------------------------------------------------------------------------
module dtwq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  dtwq_pkg::in_item_t          item_i,
  input  logic [dtwq_pkg::LimitW-1:0] limit_i,
  input  logic                        m_hit_i,
  input  logic                        m_full_i,
  input  logic                        m_empty_i,
  input  logic                        m_more_i,
  input  logic [dtwq_pkg::KeyW-1:0]   m_head_i,
  input  logic                        i_hit_i,
  input  logic                        i_full_i,
  input  logic                        i_empty_i,
  input  logic [dtwq_pkg::KeyW-1:0]   i_head_i,
  output logic [dtwq_pkg::KeyW-1:0]   key_o,
  output dtwq_pkg::chain_ctl_t        m_ctl_o,
  output dtwq_pkg::chain_ctl_t        i_ctl_o,
  output logic                        busy_o,
  output logic                        valid_o,
  output dtwq_pkg::out_item_t         result_o
);

  dtwq_pkg::state_e              state_q, state_d;
  logic [2:0]                    kind_q;
  logic [dtwq_pkg::KeyW-1:0]     key_q;
  logic [dtwq_pkg::LimitW-1:0]   cnt_q, cnt_d;
  logic                          accept;
  logic                          is_mark;
  logic                          lim_hit;

  assign accept  = start_i && (state_q == dtwq_pkg::ST_IDLE);
  assign is_mark = (item_i.kind == dtwq_pkg::KIND_DIRTY) ||
                   (item_i.kind == dtwq_pkg::KIND_REMESH) ||
                   (item_i.kind == dtwq_pkg::KIND_IDLE);
  // Count of emitted entries reaches the limit, or the result cap.
  assign lim_hit = ((limit_i != '0) && (cnt_q + 1'b1 == limit_i)) ||
                   (cnt_q == dtwq_pkg::LimitW'(dtwq_pkg::MaxResults - 1));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= item_i.kind;
      key_q  <= {item_i.coord_z, item_i.coord_y, item_i.coord_x};
    end
  end

  assign key_o = key_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      dtwq_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          if (is_mark) begin
            state_d = dtwq_pkg::ST_MARK;
          end else if (item_i.kind == dtwq_pkg::KIND_FRAME) begin
            state_d = dtwq_pkg::ST_DRAIN;
          end
        end
      end
      dtwq_pkg::ST_MARK: state_d = dtwq_pkg::ST_IDLE;
      dtwq_pkg::ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        // Stop after the final result: empty main, limit reached or no
        // entry behind the head.
        if (m_empty_i || lim_hit || !m_more_i) begin
          state_d = dtwq_pkg::ST_IDLE;
        end
      end
      default: state_d = dtwq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtwq_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Outputs: a main entry is the last of its frame when the limit is reached
  // or no entry sits behind the head.
  logic add_m, add_i, dup_i;
  always_comb begin
    m_ctl_o  = '0;
    i_ctl_o  = '0;
    valid_o  = 1'b0;
    result_o = '0;
    add_m    = 1'b0;
    add_i    = 1'b0;
    dup_i    = m_hit_i || i_hit_i;
    unique case (state_q)
      dtwq_pkg::ST_IDLE: begin
        if (start_i && !is_mark && item_i.kind != dtwq_pkg::KIND_FRAME) begin
          valid_o       = 1'b1;
          result_o.last = 1'b1;
          if (item_i.kind == dtwq_pkg::KIND_CLEAR) begin
            m_ctl_o.clear = 1'b1;
            i_ctl_o.clear = 1'b1;
          end
        end
      end
      dtwq_pkg::ST_MARK: begin
        valid_o       = 1'b1;
        result_o.last = 1'b1;
        if (kind_q == dtwq_pkg::KIND_IDLE) begin
          add_i             = !dup_i && !i_full_i;
          result_o.overflow = !dup_i && i_full_i;
          result_o.added    = add_i;
          i_ctl_o.push      = add_i;
        end else begin
          add_m             = !m_hit_i && !m_full_i;
          result_o.overflow = !m_hit_i && m_full_i;
          result_o.added    = add_m;
          m_ctl_o.push      = add_m;
        end
      end
      dtwq_pkg::ST_DRAIN: begin
        valid_o = 1'b1;
        if (!m_empty_i) begin
          result_o.emit  = 1'b1;
          {result_o.out_z, result_o.out_y, result_o.out_x} = m_head_i;
          m_ctl_o.shift  = 1'b1;
          result_o.last  = lim_hit || !m_more_i;
        end else if (!i_empty_i) begin
          result_o.emit     = 1'b1;
          result_o.promoted = 1'b1;
          {result_o.out_z, result_o.out_y, result_o.out_x} = i_head_i;
          i_ctl_o.shift     = 1'b1;
          result_o.last     = 1'b1;
        end else begin
          result_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != dtwq_pkg::ST_IDLE);

endmodule

// File: sv/dedup_two_tier_work_queue.sv
// ----------------------------------------------------------------------------
// dedup_two_tier_work_queue: deduplicating two-tier queue of chunk coordinates
// Main and idle FIFOs built as rows of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Timing: clear and unused kinds answer in the accept cycle; marks answer
// in the cycle after accept (compare in every cell, then append).
// Frame drain: first result in the cycle after accept, then one entry per
// cycle from the main head; an empty main instead yields only the idle head, if any.
// Busy blocks new items during a mark or drain; the receiver cannot stall.
// Reset empties both chains and clears frame_limit; no clearing pass.
module dedup_two_tier_work_queue #(
  parameter int unsigned MAIN_DEPTH = dtwq_pkg::MainDepthDef,
  parameter int unsigned IDLE_DEPTH = dtwq_pkg::IdleDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  dtwq_pkg::in_item_t          item_i,
  output logic                        strobe,
  output dtwq_pkg::out_item_t         result_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dtwq_pkg::LimitW-1:0] cfg_data
);

  logic [dtwq_pkg::LimitW-1:0] limit_q;
  logic [dtwq_pkg::KeyW-1:0]   key;
  dtwq_pkg::chain_ctl_t        m_ctl, i_ctl;
  logic                        m_hit, m_full, m_empty, m_more;
  logic                        i_hit, i_full, i_empty;
  logic [dtwq_pkg::KeyW-1:0]   m_head, i_head;

  // Frame limit register; writes always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid) begin
      limit_q <= cfg_data;
    end
  end

  dtwq_chain #(.Depth(MAIN_DEPTH)) u_main (
    .clk_i, .rst_ni, .ctl_i(m_ctl), .key_i(key),
    .hit_o(m_hit), .full_o(m_full), .empty_o(m_empty), .more_o(m_more),
    .head_o(m_head)
  );

  // Only the head of the idle chain is ever taken, so its depth flag is left
  // open.
  dtwq_chain #(.Depth(IDLE_DEPTH)) u_idle (
    .clk_i, .rst_ni, .ctl_i(i_ctl), .key_i(key),
    .hit_o(i_hit), .full_o(i_full), .empty_o(i_empty), .more_o(),
    .head_o(i_head)
  );

  dtwq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .item_i, .limit_i(limit_q),
    .m_hit_i(m_hit), .m_full_i(m_full), .m_empty_i(m_empty), .m_more_i(m_more),
    .m_head_i(m_head),
    .i_hit_i(i_hit), .i_full_i(i_full), .i_empty_i(i_empty), .i_head_i(i_head),
    .key_o(key), .m_ctl_o(m_ctl), .i_ctl_o(i_ctl),
    .busy_o(busy), .valid_o(strobe), .result_o
  );

endmodule
